@@ rtl/tfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants of the touch frame decoder
// Frame geometry, register indexes, event codes and the event/job records
// passed from the byte decoder to the event emitter.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int POINT_COUNT = 5;
  localparam int FRAME_BYTES = 4 + 4 * POINT_COUNT;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(POINT_COUNT + 1);
  localparam int SLOT_W      = 3;
  localparam int COORD_W     = 12;
  localparam int JOB_CNT_W   = $clog2(POINT_COUNT + 3);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT   = 3'd4;

  localparam logic [COORD_W-1:0] X_LIMIT_RESET = 12'd800;
  localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 12'd500;

  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic               swap_axes;
    logic               mirror_x;
    logic               mirror_y;
    logic [COORD_W-1:0] x_limit;
    logic [COORD_W-1:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } event_t;

  // Events caused by one byte, in delivery order: held press, new press,
  // then releases in ascending slot order.
  typedef struct packed {
    logic                   held_valid;
    event_t                 held_ev;
    logic                   new_valid;
    event_t                 new_ev;
    logic [POINT_COUNT-1:0] release_mask;
    logic                   frame_end;
  } job_t;

endpackage

@@ rtl/tfd_decoder.sv @@
// ----------------------------------------------------------------------------
// tfd_decoder: frame byte parser
// Tracks the byte position in a frame, assembles points, applies swap and
// mirror, and turns each accepted byte into a job of pending events.
// ----------------------------------------------------------------------------
module tfd_decoder (
  input  logic          clk,
  input  logic          rst,
  input  tfd_pkg::cfg_t cfg,
  input  logic          in_accept,
  input  logic [7:0]    in_byte,
  input  logic          in_start,
  output tfd_pkg::job_t job
);
  import tfd_pkg::*;

  logic                   in_frame, in_frame_next;
  logic [IDX_W-1:0]       byte_index, byte_index_next;
  logic [CNT_W-1:0]       touch_count, touch_count_next;
  logic [7:0]             x_low_hold;
  logic [3:0]             x_high_hold;
  logic [7:0]             y_low_hold;
  logic [POINT_COUNT-1:0] prev_pressed, prev_pressed_next;
  logic [POINT_COUNT-1:0] cur_pressed, cur_pressed_next;
  logic                   pending_press, pending_press_next;
  event_t                 held, held_next;

  logic                   last_byte;
  logic [IDX_W-1:0]       idx_rel;
  logic [CNT_W-1:0]       pt;
  logic [3:0]             nib;
  logic                   point_ok;
  logic [COORD_W-1:0]     raw_x, raw_y, cx, cy;
  event_t                 new_ev;

  function automatic logic [COORD_W-1:0] reflect(input logic [COORD_W-1:0] limit,
                                                 input logic [COORD_W-1:0] v);
    reflect = (v > limit) ? '0 : limit - v;
  endfunction

  always_comb begin
    last_byte = (byte_index == IDX_W'(FRAME_BYTES - 1));
    idx_rel   = byte_index - IDX_W'(4);
    pt        = CNT_W'(idx_rel >> 2);
    nib       = in_byte[7:4];
    raw_x     = {x_high_hold, x_low_hold};
    raw_y     = {in_byte[3:0], y_low_hold};
    cx        = cfg.swap_axes ? raw_y : raw_x;
    cy        = cfg.swap_axes ? raw_x : raw_y;
    if (cfg.mirror_x) cx = reflect(cfg.x_limit, cx);
    if (cfg.mirror_y) cy = reflect(cfg.y_limit, cy);
    new_ev.kind = KIND_PRESS;
    new_ev.slot = SLOT_W'(nib - 4'd1);
    new_ev.x    = cx;
    new_ev.y    = cy;
    point_ok    = in_frame && !in_start && (byte_index >= IDX_W'(4))
                  && (byte_index[1:0] == 2'd3) && (pt < touch_count)
                  && (nib >= 4'd1) && (nib <= 4'(POINT_COUNT));
  end

  always_comb begin
    in_frame_next      = in_frame;
    byte_index_next    = byte_index;
    touch_count_next   = touch_count;
    prev_pressed_next  = prev_pressed;
    cur_pressed_next   = cur_pressed;
    pending_press_next = pending_press;
    held_next          = held;
    job                = '0;
    job.held_ev        = held;
    job.new_ev         = new_ev;

    if (in_start) begin
      in_frame_next      = 1'b1;
      touch_count_next   = (in_byte > 8'(POINT_COUNT)) ? CNT_W'(POINT_COUNT)
                                                       : CNT_W'(in_byte);
      cur_pressed_next   = '0;
      pending_press_next = 1'b0;
      byte_index_next    = IDX_W'(1);
    end else if (in_frame) begin
      if (point_ok) begin
        cur_pressed_next = cur_pressed | (POINT_COUNT'(1) << new_ev.slot);
        if (last_byte) begin
          job.new_valid = 1'b1;
        end else begin
          pending_press_next = 1'b1;
          held_next          = new_ev;
        end
      end
      job.held_valid = pending_press && (point_ok || last_byte);
      if (last_byte) begin
        pending_press_next = 1'b0;
        job.release_mask   = prev_pressed & ~cur_pressed_next;
        job.frame_end      = 1'b1;
        prev_pressed_next  = cur_pressed_next;
        in_frame_next      = 1'b0;
        byte_index_next    = '0;
      end else begin
        byte_index_next = byte_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_index    <= '0;
      touch_count   <= '0;
      prev_pressed  <= '0;
      cur_pressed   <= '0;
      pending_press <= 1'b0;
    end else if (in_accept) begin
      in_frame      <= in_frame_next;
      byte_index    <= byte_index_next;
      touch_count   <= touch_count_next;
      prev_pressed  <= prev_pressed_next;
      cur_pressed   <= cur_pressed_next;
      pending_press <= pending_press_next;
    end
  end

  // Point bytes and the held press are payload: always written before use.
  always_ff @(posedge clk) begin
    if (in_accept && in_frame && !in_start && (byte_index >= IDX_W'(4))) begin
      case (byte_index[1:0])
        2'd0:    x_low_hold  <= in_byte;
        2'd1:    x_high_hold <= in_byte[3:0];
        2'd2:    y_low_hold  <= in_byte;
        default: ;
      endcase
    end
    if (in_accept) held <= held_next;
  end

endmodule

@@ rtl/tfd_emitter.sv @@
// ----------------------------------------------------------------------------
// tfd_emitter: event drain and output register
// Holds the job of the last accepted byte and moves its events, one per
// beat, into the output register; marks the final event of a frame.
// ----------------------------------------------------------------------------
module tfd_emitter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_accept,
  input  tfd_pkg::job_t          job_in,
  output logic                   job_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tfd_pkg::event_t        out_ev,
  output logic                   out_last
);
  import tfd_pkg::*;

  job_t                 job;
  logic [JOB_CNT_W-1:0] job_count;
  logic                 load, pop;
  logic [SLOT_W-1:0]    rel_slot;
  event_t               pick;

  always_comb begin
    job_count = JOB_CNT_W'(job.held_valid) + JOB_CNT_W'(job.new_valid);
    for (int s = 0; s < POINT_COUNT; s++) begin
      job_count = job_count + JOB_CNT_W'(job.release_mask[s]);
    end
    rel_slot = '0;
    for (int s = POINT_COUNT - 1; s >= 0; s--) begin
      if (job.release_mask[s]) rel_slot = SLOT_W'(s);
    end
    if (job.held_valid) begin
      pick = job.held_ev;
    end else if (job.new_valid) begin
      pick = job.new_ev;
    end else begin
      pick.kind = KIND_RELEASE;
      pick.slot = rel_slot;
      pick.x    = '0;
      pick.y    = '0;
    end
    load     = !out_valid || out_ready;
    pop      = (job_count != '0) && load;
    job_free = (job_count == '0) || ((job_count == JOB_CNT_W'(1)) && pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        job <= job_in;
      end else if (pop) begin
        if (job.held_valid)     job.held_valid <= 1'b0;
        else if (job.new_valid) job.new_valid  <= 1'b0;
        else                    job.release_mask[rel_slot] <= 1'b0;
      end
      if (load) out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ev   <= pick;
      out_last <= job.frame_end && (job_count == JOB_CNT_W'(1));
    end
  end

  a_job_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= JOB_CNT_W'(POINT_COUNT + 1))
    else $error("job holds more events than a frame end can cause");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (pop && job.frame_end && (job_count == JOB_CNT_W'(1))) |=> (out_valid && out_last))
    else $error("final event of a frame lost its sync mark");

  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_ev.kind == KIND_RELEASE)) |-> (out_ev.x == '0 && out_ev.y == '0))
    else $error("release event carries a position");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> job_free)
    else $error("new job overwrote undelivered events");

endmodule

@@ rtl/touch_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// touch_frame_decoder_unit: touch report to finger event converter
// Parses controller report bytes and emits press and release events.
//
// Usage: report bytes enter on the s_ stream, one byte per beat, with
// s_tuser high on the touch count byte that opens a frame. Events leave on
// the m_ stream: m_tuser is the event kind (0 press, 1 release), m_tlast
// marks the final event of a frame, after which a sync is due.
// Configuration (swap, mirror, limits) is written on cfg_we/cfg_index/cfg_data
// while the block is idle.
// An event caused by a byte passes through the emitter's job register and
// then its output register. Throughput: one byte per cycle while s_tready
// is high; a byte causes at most one event, except the final byte of a
// frame, which may cause up to six (a held press, its own press and
// releases). The emitter holds s_tready low while an earlier byte's events
// beyond the one in flight remain, so such a byte holds off the next byte.
// Stall: while m_tready is low the output beat holds, the event queue holds,
// and s_tready drops once the queued events for the current byte cannot
// move. Reset clears the frame state, all slots read as released, the
// registers return to their reset values and no event is pending.
// ----------------------------------------------------------------------------
module touch_frame_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
  // report byte stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] frame_byte
  input  logic                           s_tuser,  // [0] frame_start
  // event stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,  // [2:0] slot, [14:3] x_pos,
                                                   // [26:15] y_pos, [31:27] zero
  output logic                           m_tuser,  // [0] event_kind
  output logic                           m_tlast   // frame_last
);
  import tfd_pkg::*;

  cfg_t   cfg;
  job_t   job;
  event_t ev;
  logic   in_accept;

  // Hold the configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_axes <= 1'b0;
      cfg.mirror_x  <= 1'b0;
      cfg.mirror_y  <= 1'b0;
      cfg.x_limit   <= X_LIMIT_RESET;
      cfg.y_limit   <= Y_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWAP_AXES: cfg.swap_axes <= cfg_data[0];
        REG_MIRROR_X:  cfg.mirror_x  <= cfg_data[0];
        REG_MIRROR_Y:  cfg.mirror_y  <= cfg_data[0];
        REG_X_LIMIT:   cfg.x_limit   <= cfg_data;
        REG_Y_LIMIT:   cfg.y_limit   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // A byte is taken only when the emitter can take its whole job.
  assign in_accept = s_tvalid && s_tready;

  tfd_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .in_start  (s_tuser),
    .job       (job)
  );

  tfd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .job_in    (job),
    .job_free  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (ev),
    .out_last  (m_tlast)
  );

  // Pack the event fields, lowest first, zero filled to whole bytes.
  assign m_tdata = {5'd0, ev.y, ev.x, ev.slot};
  assign m_tuser = ev.kind;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for touch_frame_decoder_unit
// Feeds touch report frames one byte per beat: hand-built frames with edge
// points, stray bytes and an abandoned frame, then random frames under
// several register settings. A local decoder model predicts every press and
// release event. A monitor compares each output beat with the oldest
// prediction, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import tfd_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               frame_end;
  } touch_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] frame_byte
  logic                  s_tuser = 1'b0; // [0] frame_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [31:0]           m_tdata;        // [2:0] slot, [14:3] x_pos, [26:15] y_pos
  logic                  m_tuser;        // [0] event_kind
  logic                  m_tlast;        // frame_last

  touch_frame_decoder_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Register copy kept by the bench
  logic               cfg_swap     = 1'b0;
  logic               cfg_mirror_x = 1'b0;
  logic               cfg_mirror_y = 1'b0;
  logic [COORD_W-1:0] cfg_x_limit  = X_LIMIT_RESET;
  logic [COORD_W-1:0] cfg_y_limit  = Y_LIMIT_RESET;

  // Decoder state of the prediction
  bit                     dec_in_frame = 0;
  int                     dec_index = 0;
  int                     dec_count = 0;
  logic [7:0]             x_lo_hold = '0;
  logic [3:0]             x_hi_hold = '0;
  logic [7:0]             y_lo_hold = '0;
  logic [POINT_COUNT-1:0] slots_prev = '0;
  logic [POINT_COUNT-1:0] slots_cur = '0;
  bit                     press_on_hold = 0;
  touch_event_t           held_press;

  touch_event_t pending_events[$];

  logic [7:0] frame_buf [FRAME_BYTES];

  bit idling_on = 1'b1;
  int errors = 0;
  int beats_sent = 0;
  int frame_bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int presses_seen = 0;
  int releases_seen = 0;

  // 12 time unit clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: drop m_tready for random bursts while idling is allowed
  initial begin
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] reflect_coord(input logic [COORD_W-1:0] limit,
                                                       input logic [COORD_W-1:0] v);
    return (v > limit) ? '0 : limit - v;
  endfunction

  task automatic push_event(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    touch_event_t ev;
    ev.kind      = kind;
    ev.slot      = slot;
    ev.x         = x;
    ev.y         = y;
    ev.frame_end = 1'b0;
    pending_events.push_back(ev);
  endtask

  // Advance the decoder by one accepted report byte and queue its events
  task automatic decode_report_byte(input logic [7:0] b, input logic start);
    int                 idx;
    int                 off;
    int                 pt;
    int                 first_new;
    bit                 end_byte;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [3:0]         nib;
    touch_event_t       ev;

    if (start) begin
      // A new count byte also abandons any frame in progress
      dec_in_frame  = 1;
      dec_count     = (b > POINT_COUNT) ? POINT_COUNT : b;
      slots_cur     = '0;
      press_on_hold = 0;
      dec_index     = 1;
      return;
    end
    if (!dec_in_frame) return;

    first_new = pending_events.size();
    idx       = dec_index;
    end_byte  = (idx == FRAME_BYTES - 1);

    if (idx >= 4) begin
      off = (idx - 4) % 4;
      pt  = (idx - 4) / 4;
      if (off == 0) begin
        x_lo_hold = b;
      end else if (off == 1) begin
        x_hi_hold = b[3:0];
      end else if (off == 2) begin
        y_lo_hold = b;
      end else if (pt < dec_count) begin
        raw_x = {x_hi_hold, x_lo_hold};
        raw_y = {b[3:0], y_lo_hold};
        nib   = b[7:4];
        // Drop points whose slot nibble is zero or past the slot range
        if (nib >= 1 && nib <= POINT_COUNT) begin
          cx = cfg_swap ? raw_y : raw_x;
          cy = cfg_swap ? raw_x : raw_y;
          if (cfg_mirror_x) cx = reflect_coord(cfg_x_limit, cx);
          if (cfg_mirror_y) cy = reflect_coord(cfg_y_limit, cy);
          slots_cur[nib - 1] = 1'b1;
          if (press_on_hold)
            push_event(KIND_PRESS, held_press.slot, held_press.x, held_press.y);
          if (end_byte) begin
            press_on_hold = 0;
            push_event(KIND_PRESS, SLOT_W'(nib - 1), cx, cy);
          end else begin
            // Hold the press so the frame's final event can carry the sync
            press_on_hold   = 1;
            held_press.slot = SLOT_W'(nib - 1);
            held_press.x    = cx;
            held_press.y    = cy;
          end
        end
      end
    end

    if (end_byte) begin
      if (press_on_hold)
        push_event(KIND_PRESS, held_press.slot, held_press.x, held_press.y);
      press_on_hold = 0;
      // Release slots that were held last frame but are gone now
      for (int s = 0; s < POINT_COUNT; s++) begin
        if (slots_prev[s] && !slots_cur[s])
          push_event(KIND_RELEASE, SLOT_W'(s), '0, '0);
      end
      slots_prev = slots_cur;
      if (pending_events.size() > first_new) begin
        ev = pending_events.pop_back();
        ev.frame_end = 1'b1;
        pending_events.push_back(ev);
      end
      dec_in_frame = 0;
      dec_index    = 0;
    end else begin
      dec_index = idx + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Event monitor: compare each output beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_event
    touch_event_t want;
    touch_event_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind      = m_tuser;
      got.slot      = m_tdata[2:0];
      got.x         = m_tdata[14:3];
      got.y         = m_tdata[26:15];
      got.frame_end = m_tlast;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event: expected none, got kind %0d slot %0d x %0d y %0d last %0d",
                 $time, got.kind, got.slot, got.x, got.y, got.frame_end);
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.x !== want.x ||
            got.y !== want.y || got.frame_end !== want.frame_end) begin
          errors++;
          $display("%0t: event mismatch: expected kind %0d slot %0d x %0d y %0d last %0d",
                   $time, want.kind, want.slot, want.x, want.y, want.frame_end);
          $display("%0t:                 actual   kind %0d slot %0d x %0d y %0d last %0d",
                   $time, got.kind, got.slot, got.x, got.y, got.frame_end);
        end else if (want.kind == KIND_PRESS) begin
          presses_seen++;
        end else begin
          releases_seen++;
        end
      end
      if (m_tdata[31:27] !== 5'd0) begin
        errors++;
        $display("%0t: tdata pad mismatch: expected 0, got %0h", $time, m_tdata[31:27]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Send one report byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic start);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    decode_report_byte(b, start);
    beats_sent++;
  endtask

  // Send the first n bytes of frame_buf; fewer than a frame leaves it open
  task automatic send_frame_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
    frame_bytes_sent += n;
    if (n == FRAME_BYTES) frames_sent++;
  endtask

  task automatic put_point(input int p, input logic [3:0] nib,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    frame_buf[4 + 4 * p] = x[7:0];
    frame_buf[5 + 4 * p] = {4'($urandom), x[11:8]};  // upper nibble is junk
    frame_buf[6 + 4 * p] = y[7:0];
    frame_buf[7 + 4 * p] = {nib, y[11:8]};
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return cfg_x_limit + COORD_W'($urandom_range(0, 2)) - COORD_W'(1);
      3: return cfg_y_limit + COORD_W'($urandom_range(0, 2)) - COORD_W'(1);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Build a random frame: mostly distinct slots, now and then a bad or
  // duplicate nibble, and sometimes a count byte past the slot range
  task automatic build_random_frame();
    logic [3:0] order [POINT_COUNT];
    logic [3:0] tmp;
    logic [3:0] nib;
    int         j;
    for (int i = 0; i < POINT_COUNT; i++) order[i] = 4'(i + 1);
    for (int i = POINT_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    if ($urandom_range(0, 9) == 0) frame_buf[0] = 8'($urandom_range(POINT_COUNT + 1, 255));
    else frame_buf[0] = 8'($urandom_range(0, POINT_COUNT));
    for (int i = 1; i < 4; i++) frame_buf[i] = 8'($urandom);
    for (int p = 0; p < POINT_COUNT; p++) begin
      nib = order[p];
      if ($urandom_range(0, 9) == 0)
        nib = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(POINT_COUNT + 1, 15));
      else if ($urandom_range(0, 11) == 0)
        nib = order[$urandom_range(0, POINT_COUNT - 1)];
      put_point(p, nib, pick_coord(), pick_coord());
    end
  endtask

  // Hold the byte stream and wait until every predicted event is out
  task automatic drain_events();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0 && waited < 3000) begin
      @(posedge clk);
      waited++;
    end
    // a final byte can still be busy on up to six events
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SWAP_AXES: cfg_swap     = val[0];
      REG_MIRROR_X:  cfg_mirror_x = val[0];
      REG_MIRROR_Y:  cfg_mirror_y = val[0];
      REG_X_LIMIT:   cfg_x_limit  = val;
      REG_Y_LIMIT:   cfg_y_limit  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic swap, input logic mx, input logic my,
                            input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yl);
    drain_events();
    write_reg(REG_SWAP_AXES, CFG_DATA_W'(swap));
    write_reg(REG_MIRROR_X, CFG_DATA_W'(mx));
    write_reg(REG_MIRROR_Y, CFG_DATA_W'(my));
    write_reg(REG_X_LIMIT, xl);
    write_reg(REG_Y_LIMIT, yl);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Bytes with no frame open must be ignored
  task automatic test_stray_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Clamped count, coordinate extremes, bad nibbles, a duplicate slot; then a
  // one-point frame so the other slots are released
  task automatic test_edge_points();
    frame_buf[0] = 8'hFF;
    frame_buf[1] = 8'hFF;
    frame_buf[2] = 8'h00;
    frame_buf[3] = 8'hA5;
    put_point(0, 4'd1, 12'hFFF, 12'h000);
    put_point(1, 4'd5, 12'h000, 12'hFFF);
    put_point(2, 4'd0, 12'h123, 12'h456);
    put_point(3, 4'hF, 12'h789, 12'hABC);
    put_point(4, 4'd1, X_LIMIT_RESET, Y_LIMIT_RESET);
    send_frame_bytes(FRAME_BYTES);
    frame_buf[0] = 8'd1;
    put_point(0, 4'd3, 12'h5A5, 12'hA5A);
    send_frame_bytes(FRAME_BYTES);
  endtask

  // A count byte mid-frame drops the held press and the partial slot set
  task automatic test_early_start();
    frame_buf[0] = 8'd3;
    put_point(0, 4'd2, 12'h111, 12'h222);
    put_point(1, 4'd4, 12'h333, 12'h444);
    send_frame_bytes(10);
    frame_buf[0] = 8'd0;
    send_frame_bytes(FRAME_BYTES);
  endtask

  // Random traffic until the frame byte count reaches the target
  task automatic test_random_frames(input int target);
    int pick;
    while (frame_bytes_sent < target) begin
      pick = $urandom_range(0, 19);
      build_random_frame();
      if (pick == 0) begin
        send_byte(8'($urandom), 1'b0);
      end else if (pick <= 2) begin
        send_frame_bytes($urandom_range(1, FRAME_BYTES - 1));
        build_random_frame();
        send_frame_bytes(FRAME_BYTES);
      end else begin
        send_frame_bytes(FRAME_BYTES);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_stray_bytes();
    test_edge_points();
    test_early_start();
    test_random_frames(130);

    set_config(1'b1, 1'b1, 1'b1, 12'hFFF, 12'hFFF);
    test_random_frames(230);

    set_config(1'b0, 1'b1, 1'b1, 12'h000, 12'h000);
    test_random_frames(330);

    // last stretch runs with both streams at full rate
    set_config(1'b1, 1'b0, 1'b1, COORD_W'($urandom), COORD_W'($urandom));
    idling_on = 1'b0;
    test_random_frames(430);

    drain_events();
    if (pending_events.size() != 0) begin
      errors += pending_events.size();
      $display("%0t: missing events: expected %0d more, got none", $time,
               pending_events.size());
    end

    $display("Sent %0d report beats (%0d full frames) over %0d register settings.",
             beats_sent, frames_sent, settings_used);
    $display("Checked %0d press and %0d release events, %0d errors.",
             presses_seen, releases_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ touch_frame_decoder_unit.f @@
rtl/tfd_pkg.sv
rtl/tfd_decoder.sv
rtl/tfd_emitter.sv
rtl/touch_frame_decoder_unit.sv
dv/testbench.sv
